// File: hw/rtl/crg_pkg.sv
// Shared types and constants for the camera ray generator.
// Used by every module under hw/rtl; depends on nothing.
package crg_pkg;

    localparam int MAX_DIM       = 4096;
    localparam int DIM_W         = 13;
    localparam int PIX_W         = 12;
    localparam int COMP_W        = 21;
    localparam int BASIS_W       = 3 * COMP_W;
    localparam int POS_W         = 32;
    localparam int ABC_W         = 27;
    localparam int PROD_W        = COMP_W + ABC_W;
    localparam int DSUM_W        = PROD_W + 2;
    localparam int MAG_W         = DSUM_W - 1;
    localparam int NORM_BITS     = 30;
    localparam int SHIFT_W       = 5;
    localparam int SQ_W          = 2 * NORM_BITS;
    localparam int SUM_W         = SQ_W + 2;
    localparam int ROOT_W        = SUM_W / 2;
    localparam int ROOT_STAGES   = 32;
    localparam int ISQ_W         = 63;
    localparam int DIR_FRAC_BITS = 16;
    localparam int Q_W           = DIR_FRAC_BITS + 1;
    localparam int DIV_W         = 48;
    localparam int DEN_W         = ROOT_W + 1;
    localparam int OUT_DIR_BITS  = 18;
    localparam int CFG_ADDR_W    = 3;
    localparam int CFG_DATA_W    = 63;

    localparam logic [CFG_ADDR_W-1:0] REG_IMG_WIDTH  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_IMG_HEIGHT = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_RIGHT      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_UP         = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_VIEW       = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_POS_X      = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_POS_Y      = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_POS_Z      = 3'd7;

    typedef struct packed {
        logic [DIM_W-1:0]                  w;
        logic [DIM_W-1:0]                  h;
        logic [2:0][COMP_W-1:0]            right;
        logic [2:0][COMP_W-1:0]            up;
        logic [2:0][COMP_W-1:0]            view;
        logic [2:0][POS_W-1:0]             pos;
    } cfg_t;

    // Per-component data that rides along with the length computation.
    typedef struct packed {
        logic [2:0][NORM_BITS-1:0] mag;
        logic [2:0]                neg;
    } side_t;

endpackage

// File: hw/rtl/crg_config.sv
// Configuration register file of the camera ray generator.
// Depends on crg_pkg.
module crg_config (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [crg_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [crg_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output crg_pkg::cfg_t                    cfg
);

    logic [crg_pkg::DIM_W-1:0]   w_reg, h_reg;
    logic [crg_pkg::BASIS_W-1:0] right_reg, up_reg, view_reg;
    logic [crg_pkg::POS_W-1:0]   px_reg, py_reg, pz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg     <= crg_pkg::DIM_W'(640);
            h_reg     <= crg_pkg::DIM_W'(480);
            right_reg <= '0;
            up_reg    <= '0;
            view_reg  <= '0;
            px_reg    <= '0;
            py_reg    <= '0;
            pz_reg    <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                crg_pkg::REG_IMG_WIDTH:  w_reg     <= cfg_wdata[crg_pkg::DIM_W-1:0];
                crg_pkg::REG_IMG_HEIGHT: h_reg     <= cfg_wdata[crg_pkg::DIM_W-1:0];
                crg_pkg::REG_RIGHT:      right_reg <= cfg_wdata[crg_pkg::BASIS_W-1:0];
                crg_pkg::REG_UP:         up_reg    <= cfg_wdata[crg_pkg::BASIS_W-1:0];
                crg_pkg::REG_VIEW:       view_reg  <= cfg_wdata[crg_pkg::BASIS_W-1:0];
                crg_pkg::REG_POS_X:      px_reg    <= cfg_wdata[crg_pkg::POS_W-1:0];
                crg_pkg::REG_POS_Y:      py_reg    <= cfg_wdata[crg_pkg::POS_W-1:0];
                crg_pkg::REG_POS_Z:      pz_reg    <= cfg_wdata[crg_pkg::POS_W-1:0];
                default: ;
            endcase
        end
    end

    // A size of zero acts as one, and sizes above the maximum are limited.
    function automatic logic [crg_pkg::DIM_W-1:0] clamp_dim(input logic [crg_pkg::DIM_W-1:0] v);
        logic [crg_pkg::DIM_W-1:0] r;
        r = v;
        if (v == '0) r = crg_pkg::DIM_W'(1);
        if (v > crg_pkg::DIM_W'(crg_pkg::MAX_DIM)) r = crg_pkg::DIM_W'(crg_pkg::MAX_DIM);
        return r;
    endfunction

    always_comb begin
        cfg.w     = clamp_dim(w_reg);
        cfg.h     = clamp_dim(h_reg);
        cfg.right = right_reg;
        cfg.up    = up_reg;
        cfg.view  = view_reg;
        cfg.pos   = {pz_reg, py_reg, px_reg};
    end

endmodule

// File: hw/rtl/crg_front.sv
// Front pipeline: pixel offsets, basis products, magnitude scaling and squares.
// Seven register stages; depends on crg_pkg.
module crg_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  crg_pkg::cfg_t                 cfg,
    input  logic                          in_valid,
    input  logic [crg_pkg::PIX_W-1:0]     in_x,
    input  logic [crg_pkg::PIX_W-1:0]     in_y,
    output logic                          out_valid,
    output logic [crg_pkg::SUM_W-1:0]     out_sum,
    output crg_pkg::side_t                out_side
);

    localparam int AW = crg_pkg::ABC_W;

    // Stage 1: A = 2xH - W*W, B = 2yH - H*H, C = 2H*H.
    logic                 v1_reg;
    logic signed [AW-1:0] a_reg, b_reg, c_reg;
    logic [2*crg_pkg::DIM_W-1:0] xh, yh, ww, hh;

    assign xh = (2*crg_pkg::DIM_W)'({1'b0, in_x}) * (2*crg_pkg::DIM_W)'(cfg.h);
    assign yh = (2*crg_pkg::DIM_W)'({1'b0, in_y}) * (2*crg_pkg::DIM_W)'(cfg.h);
    assign ww = (2*crg_pkg::DIM_W)'(cfg.w) * (2*crg_pkg::DIM_W)'(cfg.w);
    assign hh = (2*crg_pkg::DIM_W)'(cfg.h) * (2*crg_pkg::DIM_W)'(cfg.h);

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg <= $signed(AW'({xh, 1'b0})) - $signed(AW'(ww));
            b_reg <= $signed(AW'({yh, 1'b0})) - $signed(AW'(hh));
            c_reg <= $signed(AW'({hh, 1'b0}));
        end
    end

    // Stage 2: nine products.
    logic v2_reg;
    logic signed [crg_pkg::PROD_W-1:0] pr_reg [3], pu_reg [3], pv_reg [3];

    // Stage 3: signed sum, then sign and magnitude.
    logic v3_reg;
    logic [crg_pkg::MAG_W-1:0] mag_reg [3];
    logic [2:0]                neg3_reg;

    // Stage 4: scale shift so the largest magnitude fits the norm width.
    logic v4_reg;
    logic [crg_pkg::MAG_W-1:0]   mag4_reg [3];
    logic [2:0]                  neg4_reg;
    logic [crg_pkg::SHIFT_W-1:0] sh_reg;
    logic [crg_pkg::MAG_W-1:0]   mag_or;
    logic [crg_pkg::SHIFT_W-1:0] sh_next;

    // Stage 5: scaled magnitudes. Stage 6: squares. Stage 7: sum of squares.
    logic v5_reg, v6_reg, v7_reg;
    crg_pkg::side_t side5_reg, side6_reg, side7_reg;
    logic [crg_pkg::SQ_W-1:0]  sq_reg [3];
    logic [crg_pkg::SUM_W-1:0] sum_reg;

    always_comb begin
        mag_or  = mag_reg[0] | mag_reg[1] | mag_reg[2];
        sh_next = '0;
        for (int i = crg_pkg::NORM_BITS; i < crg_pkg::MAG_W; i++) begin
            if (mag_or[i]) sh_next = crg_pkg::SHIFT_W'(i - crg_pkg::NORM_BITS + 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                pr_reg[k] <= $signed(cfg.right[k]) * a_reg;
                pu_reg[k] <= $signed(cfg.up[k]) * b_reg;
                pv_reg[k] <= $signed(cfg.view[k]) * c_reg;
            end
            for (int k = 0; k < 3; k++) begin
                logic signed [crg_pkg::DSUM_W-1:0] d;
                d = crg_pkg::DSUM_W'(pr_reg[k]) + crg_pkg::DSUM_W'(pu_reg[k])
                    + crg_pkg::DSUM_W'(pv_reg[k]);
                neg3_reg[k] <= d[crg_pkg::DSUM_W-1];
                mag_reg[k]  <= d[crg_pkg::DSUM_W-1] ? crg_pkg::MAG_W'(-d) : crg_pkg::MAG_W'(d);
            end
            mag4_reg <= mag_reg;
            neg4_reg <= neg3_reg;
            sh_reg   <= sh_next;
            for (int k = 0; k < 3; k++) begin
                side5_reg.mag[k] <= crg_pkg::NORM_BITS'(mag4_reg[k] >> sh_reg);
                sq_reg[k] <= crg_pkg::SQ_W'(side5_reg.mag[k]) * crg_pkg::SQ_W'(side5_reg.mag[k]);
            end
            side5_reg.neg <= neg4_reg;
            side6_reg     <= side5_reg;
            side7_reg     <= side6_reg;
            sum_reg <= crg_pkg::SUM_W'(sq_reg[0]) + crg_pkg::SUM_W'(sq_reg[1])
                       + crg_pkg::SUM_W'(sq_reg[2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            {v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg} <= '0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    assign out_valid = v7_reg;
    assign out_sum   = sum_reg;
    assign out_side  = side7_reg;

endmodule

// File: hw/rtl/crg_isqrt.sv
// Pipelined integer square root, one result bit per stage from each radicand bit pair.
// Carries the per-component side data alongside; depends on crg_pkg.
module crg_isqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [crg_pkg::SUM_W-1:0]     in_sum,
    input  crg_pkg::side_t                in_side,
    output logic                          out_valid,
    output logic [crg_pkg::ROOT_W-1:0]    out_len,
    output crg_pkg::side_t                out_side
);

    localparam int NS = crg_pkg::ROOT_STAGES;
    localparam int W  = crg_pkg::ISQ_W;

    logic [W-1:0]   n_s   [0:NS];
    logic [W-1:0]   res_s [0:NS];
    logic           v_s   [0:NS];
    crg_pkg::side_t sd_s  [0:NS];

    logic [W-1:0]   n_reg   [1:NS];
    logic [W-1:0]   res_reg [1:NS];
    logic           v_reg   [1:NS];
    crg_pkg::side_t sd_reg  [1:NS];

    assign n_s[0]   = W'(in_sum);
    assign res_s[0] = '0;
    assign v_s[0]   = in_valid;
    assign sd_s[0]  = in_side;

    for (genvar k = 0; k < NS; k++) begin : g_stage
        localparam logic [W-1:0] BIT = W'(1) << (W - 1 - 2*k);
        logic [W-1:0] t;
        assign t = res_s[k] + BIT;

        always_ff @(posedge aclk) begin
            if (en) begin
                if (n_s[k] >= t) begin
                    n_reg[k+1]   <= n_s[k] - t;
                    res_reg[k+1] <= (res_s[k] >> 1) + BIT;
                end else begin
                    n_reg[k+1]   <= n_s[k];
                    res_reg[k+1] <= res_s[k] >> 1;
                end
                sd_reg[k+1] <= sd_s[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k+1] <= 1'b0;
            end else if (en) begin
                v_reg[k+1] <= v_s[k];
            end
        end

        assign n_s[k+1]   = n_reg[k+1];
        assign res_s[k+1] = res_reg[k+1];
        assign v_s[k+1]   = v_reg[k+1];
        assign sd_s[k+1]  = sd_reg[k+1];
    end

    assign out_valid = v_s[NS];
    assign out_len   = res_s[NS][crg_pkg::ROOT_W-1:0];
    assign out_side  = sd_s[NS];

endmodule

// File: hw/rtl/crg_divider.sv
// Pipelined restoring divider with a rounded quotient for three lanes sharing
// one divisor, then sign and range encoding of the direction. Depends on crg_pkg.
module crg_divider (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         en,
    input  logic                                         in_valid,
    input  logic [crg_pkg::ROOT_W-1:0]                   in_len,
    input  crg_pkg::side_t                               in_side,
    output logic                                         out_valid,
    output logic [2:0][crg_pkg::OUT_DIR_BITS-1:0]        out_dir
);

    localparam int NS = crg_pkg::Q_W;
    localparam int RW = crg_pkg::DIV_W;

    logic [2:0][RW-1:0]               r_s   [0:NS];
    logic [2:0][NS-1:0]               q_s   [0:NS];
    logic [crg_pkg::DEN_W-1:0]        d_s   [0:NS];
    logic [2:0]                       neg_s [0:NS];
    logic                             z_s   [0:NS];
    logic                             v_s   [0:NS];

    logic [2:0][RW-1:0]               r_reg   [1:NS];
    logic [2:0][NS-1:0]               q_reg   [1:NS];
    logic [crg_pkg::DEN_W-1:0]        d_reg   [1:NS];
    logic [2:0]                       neg_reg [1:NS];
    logic                             z_reg   [1:NS];
    logic                             v_reg   [1:NS];

    // Numerator is mag * 2^(F+1) + len, divisor 2*len: a rounded quotient.
    for (genvar l = 0; l < 3; l++) begin : g_init
        assign r_s[0][l] = RW'({in_side.mag[l], {NS{1'b0}}}) + RW'(in_len);
        assign q_s[0][l] = '0;
    end
    assign d_s[0]   = {in_len, 1'b0};
    assign neg_s[0] = in_side.neg;
    assign z_s[0]   = (in_len == '0);
    assign v_s[0]   = in_valid;

    for (genvar k = 0; k < NS; k++) begin : g_stage
        localparam int SH = NS - 1 - k;
        logic [RW-1:0] dsh;
        assign dsh = RW'(d_s[k]) << SH;

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int l = 0; l < 3; l++) begin
                    if (r_s[k][l] >= dsh) begin
                        r_reg[k+1][l]     <= r_s[k][l] - dsh;
                        q_reg[k+1][l]     <= q_s[k][l] | (NS'(1) << SH);
                    end else begin
                        r_reg[k+1][l]     <= r_s[k][l];
                        q_reg[k+1][l]     <= q_s[k][l];
                    end
                end
                d_reg[k+1]   <= d_s[k];
                neg_reg[k+1] <= neg_s[k];
                z_reg[k+1]   <= z_s[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k+1] <= 1'b0;
            end else if (en) begin
                v_reg[k+1] <= v_s[k];
            end
        end

        assign r_s[k+1]   = r_reg[k+1];
        assign q_s[k+1]   = q_reg[k+1];
        assign d_s[k+1]   = d_reg[k+1];
        assign neg_s[k+1] = neg_reg[k+1];
        assign z_s[k+1]   = z_reg[k+1];
        assign v_s[k+1]   = v_reg[k+1];
    end

    // Encode stage: limit to one in magnitude, apply sign, zero length gives zero.
    localparam logic [NS-1:0] ONE = NS'(1) << crg_pkg::DIR_FRAC_BITS;
    logic                                    ov_reg;
    logic [2:0][crg_pkg::OUT_DIR_BITS-1:0]   dir_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                logic [NS-1:0] q;
                q = (q_s[NS][l] > ONE) ? ONE : q_s[NS][l];
                if (z_s[NS]) begin
                    dir_reg[l] <= '0;
                end else if (neg_s[NS][l]) begin
                    dir_reg[l] <= -crg_pkg::OUT_DIR_BITS'(q);
                end else begin
                    dir_reg[l] <= crg_pkg::OUT_DIR_BITS'(q);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (en) begin
            ov_reg <= v_s[NS];
        end
    end

    assign out_valid = ov_reg;
    assign out_dir   = dir_reg;

endmodule

// File: hw/rtl/camera_ray_generation.sv
// Camera ray generator top level: configuration, pipeline and output buffering.
// Depends on crg_pkg, crg_config, crg_front, crg_isqrt and crg_divider.

// Takes one pixel coordinate per cycle, unless the skid entry is full, and
// returns the normalized pinhole camera ray for it, with the camera position
// as origin. Throughput is one transaction per clock while the skid entry is
// empty. A result passes through the seven-stage product and scaling front
// end, the 32-stage square root, the 17-stage divider with its encode stage,
// and the output register. The output register has a skid entry behind it,
// so the input keeps flowing until both hold results.
// The user must write configuration registers only while no transaction is in
// flight; the block itself does not enforce this.
module camera_ray_generation (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [crg_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [crg_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [23:0]                         s_tdata,  // pixel_x, pixel_y
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // dir_x, dir_y, dir_z, origin_x, origin_y, origin_z, 2 zero bits
    output logic [151:0]                        m_tdata
);

    localparam int DB = crg_pkg::OUT_DIR_BITS;

    crg_pkg::cfg_t cfg;
    logic en;
    logic f_valid, q_valid, p_valid;
    logic [crg_pkg::SUM_W-1:0]  f_sum;
    crg_pkg::side_t             f_side, q_side;
    logic [crg_pkg::ROOT_W-1:0] q_len;
    logic [2:0][DB-1:0]         p_dir;

    logic               out_valid_reg, skid_valid_reg;
    logic [2:0][DB-1:0] out_dir_reg, skid_dir_reg;
    logic               out_free;

    crg_config u_config (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata), .cfg(cfg)
    );

    crg_front u_front (
        .aclk(aclk), .aresetn(aresetn), .en(en), .cfg(cfg),
        .in_valid(s_tvalid && s_tready), .in_x(s_tdata[11:0]), .in_y(s_tdata[23:12]),
        .out_valid(f_valid), .out_sum(f_sum), .out_side(f_side)
    );

    crg_isqrt u_isqrt (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(f_valid), .in_sum(f_sum),
        .in_side(f_side), .out_valid(q_valid), .out_len(q_len), .out_side(q_side)
    );

    crg_divider u_divider (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(q_valid), .in_len(q_len),
        .in_side(q_side), .out_valid(p_valid), .out_dir(p_dir)
    );

    // The pipeline moves whenever the skid entry is empty; the item leaving it
    // goes to the output register if that is free, otherwise to the skid entry.
    assign en       = !skid_valid_reg;
    assign s_tready = en;
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (out_free) begin
            out_valid_reg <= p_valid;
        end else if (p_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_tready) out_dir_reg <= skid_dir_reg;
        end else if (out_free) begin
            out_dir_reg <= p_dir;
        end else begin
            skid_dir_reg <= p_dir;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, cfg.pos[2], cfg.pos[1], cfg.pos[0],
                       out_dir_reg[2], out_dir_reg[1], out_dir_reg[0]};

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds data while the output register is empty");

    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_tready && p_valid))
        else $error("skid entry filled without a stalled output");

    a_no_accept_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> !skid_valid_reg)
        else $error("input accepted while the skid entry is occupied");

endmodule

// File: verif/tb_camera_ray_generation.sv
// Self-checking testbench for camera_ray_generation: directed table, then random pixels
// over several camera set-ups, checked against a built-in ray predictor or the zero ray.
// Depends on crg_pkg and the camera_ray_generation RTL.
module tb_camera_ray_generation;
    timeunit 1ns;
    timeprecision 1ps;
    import crg_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int RAND_PHASES    = 8;
    localparam int ITEMS_PER_PHASE = 135;

    typedef struct packed {
        logic [OUT_DIR_BITS-1:0] dx;
        logic [OUT_DIR_BITS-1:0] dy;
        logic [OUT_DIR_BITS-1:0] dz;
        logic [POS_W-1:0]        ox;
        logic [POS_W-1:0]        oy;
        logic [POS_W-1:0]        oz;
    } ray_t;

    typedef struct {
        int          phase;
        logic [11:0] x;
        logic [11:0] y;
        bit          known;  // result is the all-zero ray of the reset set-up
    } pixel_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [23:0]           s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [151:0]          m_tdata;

    camera_ray_generation dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Camera set-up as the block should currently hold it.
    logic [DIM_W-1:0]   cam_w = 13'd640;
    logic [DIM_W-1:0]   cam_h = 13'd480;
    logic [BASIS_W-1:0] cam_right = '0, cam_up = '0, cam_view = '0;
    logic [POS_W-1:0]   cam_pos [3] = '{default: '0};

    ray_t ray_queue[$];
    int   mismatches = 0;
    int   rays_sent = 0;
    int   rays_checked = 0;
    int   idle_cycles = 0;
    int   hold_req = 0;
    bit   rx_always_ready = 0;

    function automatic longint img_dim(logic [DIM_W-1:0] r);
        if (r == 0) return 1;
        if (r > MAX_DIM) return MAX_DIM;
        return longint'(r);
    endfunction

    function automatic longint basis_comp(logic [BASIS_W-1:0] v, int k);
        logic signed [COMP_W-1:0] c;
        c = v[k*COMP_W +: COMP_W];
        return longint'(c);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic ray_t predict_ray(logic [11:0] px, logic [11:0] py);
        longint w, h, a, b, c, d;
        longint unsigned mag [3];
        bit neg [3];
        longint unsigned m, sum, len, q;
        longint v;
        int s;
        logic [OUT_DIR_BITS-1:0] dirs [3];
        ray_t r;
        w = img_dim(cam_w);
        h = img_dim(cam_h);
        a = 2 * longint'(px) * h - w * w;
        b = 2 * longint'(py) * h - h * h;
        c = 2 * h * h;
        m = 0;
        for (int k = 0; k < 3; k++) begin
            d = basis_comp(cam_right, k) * a + basis_comp(cam_up, k) * b
                + basis_comp(cam_view, k) * c;
            neg[k] = d < 0;
            mag[k] = neg[k] ? longint'(-d) : d;
            if (mag[k] > m) m = mag[k];
        end
        s = 0;
        while ((m >> s) >= (64'd1 << NORM_BITS)) s++;
        sum = 0;
        for (int k = 0; k < 3; k++) begin
            mag[k] >>= s;
            sum += mag[k] * mag[k];
        end
        len = int_sqrt(sum);
        for (int k = 0; k < 3; k++) begin
            v = 0;
            if (len != 0) begin
                // Round half away from zero on the magnitude.
                q = ((mag[k] << (DIR_FRAC_BITS + 1)) + len) / (2 * len);
                v = neg[k] ? -longint'(q) : longint'(q);
            end
            if (v > (64'sd1 <<< DIR_FRAC_BITS)) v = 64'sd1 <<< DIR_FRAC_BITS;
            if (v < -(64'sd1 <<< DIR_FRAC_BITS)) v = -(64'sd1 <<< DIR_FRAC_BITS);
            dirs[k] = v[OUT_DIR_BITS-1:0];
        end
        r.dx = dirs[0]; r.dy = dirs[1]; r.dz = dirs[2];
        r.ox = cam_pos[0]; r.oy = cam_pos[1]; r.oz = cam_pos[2];
        return r;
    endfunction

    // Result checker and watchdog share the handshake sampling at the clock edge.
    always @(posedge aclk) begin
        ray_t got, want;
        got.dx = m_tdata[17:0];    got.dy = m_tdata[35:18];   got.dz = m_tdata[53:36];
        got.ox = m_tdata[85:54];   got.oy = m_tdata[117:86];  got.oz = m_tdata[149:118];
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            rays_checked++;
            if (ray_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected ray result %h", got);
            end else begin
                want = ray_queue.pop_front();
                if (got !== want || m_tdata[151:150] !== 2'b00) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Ray mismatch: dir exp %0d %0d %0d got %0d %0d %0d",
                                 $signed(want.dx), $signed(want.dy), $signed(want.dz),
                                 $signed(got.dx), $signed(got.dy), $signed(got.dz));
                        $display("  origin exp %h %h %h got %h %h %h",
                                 want.ox, want.oy, want.oz, got.ox, got.oy, got.oz);
                    end
                end
            end
        end
    end

    // Receiver: random back-pressure, occasional long stalls, one forced long hold-off.
    always @(posedge aclk) begin
        static int stall_left = 0;
        static int holds_seen = 0;
        if (holds_seen != hold_req) begin
            holds_seen = hold_req;
            stall_left = 400;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (rx_always_ready) begin
            m_tready <= 1'b1;
        end else if ($urandom_range(99) < 2) begin
            stall_left = $urandom_range(60, 10);
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) < 70);
        end
    end

    task automatic cfg_write(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            REG_IMG_WIDTH:  cam_w = val[DIM_W-1:0];
            REG_IMG_HEIGHT: cam_h = val[DIM_W-1:0];
            REG_RIGHT:      cam_right = val[BASIS_W-1:0];
            REG_UP:         cam_up = val[BASIS_W-1:0];
            REG_VIEW:       cam_view = val[BASIS_W-1:0];
            REG_POS_X:      cam_pos[0] = val[POS_W-1:0];
            REG_POS_Y:      cam_pos[1] = val[POS_W-1:0];
            REG_POS_Z:      cam_pos[2] = val[POS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_camera(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h,
                                logic [CFG_DATA_W-1:0] rt, logic [CFG_DATA_W-1:0] upv,
                                logic [CFG_DATA_W-1:0] vw, logic [CFG_DATA_W-1:0] px,
                                logic [CFG_DATA_W-1:0] py, logic [CFG_DATA_W-1:0] pz);
        // Nothing in flight: every result in, then the pipeline latency again.
        while (ray_queue.size() != 0) @(posedge aclk);
        repeat (70) @(posedge aclk);
        cfg_write(REG_IMG_WIDTH, w);
        cfg_write(REG_IMG_HEIGHT, h);
        cfg_write(REG_RIGHT, rt);
        cfg_write(REG_UP, upv);
        cfg_write(REG_VIEW, vw);
        cfg_write(REG_POS_X, px);
        cfg_write(REG_POS_Y, py);
        cfg_write(REG_POS_Z, pz);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [BASIS_W-1:0] pack_basis(int cx, int cy, int cz);
        logic [COMP_W-1:0] a, b, c;
        a = COMP_W'(cx); b = COMP_W'(cy); c = COMP_W'(cz);
        return {c, b, a};
    endfunction

    // Offers one pixel and waits for its transaction, then idles for the given gap.
    task automatic send_pixel(logic [11:0] px, logic [11:0] py, int gap);
        s_tvalid <= 1'b1;
        s_tdata <= {py, px};
        do @(posedge aclk); while (!s_tready);
        ray_queue.push_back(predict_ray(px, py));
        rays_sent++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    function automatic int sender_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 5);
    endfunction

    localparam int UNIT = 1 << 19;
    localparam int CMAX = (1 << 20) - 1;
    localparam int CMIN = -(1 << 20);

    // Random register word over the full configuration data width.
    function automatic logic [CFG_DATA_W-1:0] rand_word();
        return CFG_DATA_W'({$urandom, $urandom});
    endfunction

    // Random basis component within one unit of zero.
    function automatic int rand_comp();
        return int'($urandom_range(2 * UNIT)) - UNIT;
    endfunction

    pixel_row_t pixel_table [] = '{
        '{0, 12'd0,    12'd0,    1'b1},
        '{0, 12'd4095, 12'd4095, 1'b1},
        '{0, 12'd0,    12'd4095, 1'b1},
        '{0, 12'd4095, 12'd0,    1'b1},
        '{0, 12'd320,  12'd240,  1'b1},
        '{1, 12'd320,  12'd240,  1'b0},
        '{1, 12'd0,    12'd0,    1'b0},
        '{1, 12'd639,  12'd479,  1'b0},
        '{1, 12'd639,  12'd0,    1'b0},
        '{1, 12'd0,    12'd479,  1'b0},
        '{1, 12'd4095, 12'd4095, 1'b0},
        '{1, 12'd2048, 12'd1,    1'b0},
        '{2, 12'd0,    12'd0,    1'b0},
        '{2, 12'd4095, 12'd4095, 1'b0},
        '{2, 12'd1,    12'd2048, 1'b0},
        '{2, 12'd2730, 12'd1365, 1'b0},
        '{3, 12'd0,    12'd0,    1'b0},
        '{3, 12'd4095, 12'd0,    1'b0},
        '{3, 12'd0,    12'd4095, 1'b0},
        '{3, 12'd2047, 12'd2048, 1'b0}
    };

    initial begin
        int cur_phase;
        int wv, hv;
        logic [11:0] px, py;
        ray_t zero_ray;
        zero_ray = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        cur_phase = 0;
        foreach (pixel_table[i]) begin
            if (pixel_table[i].phase != cur_phase) begin
                s_tvalid <= 1'b0;
                cur_phase = pixel_table[i].phase;
                case (cur_phase)
                    1: apply_camera(640, 480, pack_basis(UNIT, 0, 0), pack_basis(0, UNIT, 0),
                                    pack_basis(0, 0, -UNIT), 32'h7FFF_FFFF, 32'h8000_0000,
                                    32'hFFFF_FFFF);
                    // Zero width and oversize height, extreme basis components.
                    2: apply_camera(0, 13'h1FFF, pack_basis(CMAX, CMIN, CMAX),
                                    pack_basis(CMIN, CMAX, CMIN), pack_basis(CMAX, CMAX, CMIN),
                                    32'h0001_0000, 0, 32'h8000_0001);
                    default: apply_camera(1, 4096, pack_basis(CMIN, CMIN, CMIN),
                                    pack_basis(CMIN, CMIN, CMIN), pack_basis(CMIN, CMIN, CMIN),
                                    32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678);
                endcase
            end
            send_pixel(pixel_table[i].x, pixel_table[i].y, sender_gap());
            // The reset set-up has a zero basis, so every ray is the zero ray at the origin.
            if (pixel_table[i].known)
                ray_queue[ray_queue.size()-1] = zero_ray;
        end
        s_tvalid <= 1'b0;

        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0: begin wv = 1; hv = 1; end
                1: begin wv = 4096; hv = 4096; end
                2: begin wv = 8191; hv = 5000; end
                3: begin wv = 0; hv = 0; end
                default: begin wv = $urandom_range(4096, 1); hv = $urandom_range(4096, 1); end
            endcase
            if (p == 4)
                apply_camera(wv, hv, 0, 0, 0, rand_word(), rand_word(), rand_word());
            else if (p % 2 == 0)
                apply_camera(wv, hv, rand_word(), rand_word(), rand_word(),
                             rand_word(), rand_word(), rand_word());
            else
                apply_camera(wv, hv,
                             pack_basis(rand_comp(), rand_comp(), 0),
                             pack_basis(0, rand_comp(), rand_comp()),
                             pack_basis(rand_comp(), 0, rand_comp()),
                             rand_word(), rand_word(), rand_word());
            rx_always_ready <= (p == 5);
            if (p == 2) hold_req <= hold_req + 1;
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if ($urandom_range(99) < 80) begin
                    px = PIX_W'($urandom_range(
                             32'(img_dim(cam_w) > 4095 ? 4095 : img_dim(cam_w) - 1)));
                    py = PIX_W'($urandom_range(
                             32'(img_dim(cam_h) > 4095 ? 4095 : img_dim(cam_h) - 1)));
                end else begin
                    px = PIX_W'($urandom);
                    py = PIX_W'($urandom);
                end
                send_pixel(px, py, (p == 5 || p == 2) ? 0 : sender_gap());
            end
            s_tvalid <= 1'b0;
        end
        rx_always_ready <= 1'b0;

        while (ray_queue.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Covered %0d pixels over %0d camera set-ups; %0d rays checked, %0d mismatches.",
                 rays_sent, RAND_PHASES + 4, rays_checked, mismatches);
        if (mismatches == 0 && ray_queue.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

// File: sim.f
hw/rtl/crg_pkg.sv
hw/rtl/crg_config.sv
hw/rtl/crg_front.sv
hw/rtl/crg_isqrt.sv
hw/rtl/crg_divider.sv
hw/rtl/camera_ray_generation.sv
verif/tb_camera_ray_generation.sv
